// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define BFRR_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");

// Checks that a condition never holds outside reset.
`define BFRR_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== rtl/bfrr_pkg.sv =====
package bfrr_pkg;

  localparam int MaxSrcWidth  = 256;
  localparam int MaxSrcHeight = 256;
  localparam int MaxDstDim    = 4096;

  localparam int DivNumW  = 25;
  localparam int DivDenW  = 17;
  localparam int DivCntW  = 5;
  localparam int SumW     = 24;
  localparam int SpanW    = 9;
  localparam int CountW   = 17;
  localparam int AddrW    = 16;
  localparam int PixW     = 32;
  localparam int Channels = 4;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DSTART, ST_DWAIT, ST_WINIT, ST_WALK, ST_DRAIN, ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    OP_X0, OP_X1, OP_Y0, OP_Y1, OP_M0, OP_M1, OP_M2, OP_M3
  } op_e;

  typedef struct packed {
    logic s_ready;
    logic div_start;
    op_e  op;
    logic walk_init;
    logic walk_rd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic zero_dim;
    logic div_done;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/bfrr_div.sv =====
module bfrr_div import bfrr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quot_o
);

  logic [DivNumW-1:0] nq_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;
  logic               ge;

  assign trial = {rem_q, nq_q[DivNumW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivNumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      nq_q  <= {nq_q[DivNumW-2:0], ge};
      rem_q <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

// ===== rtl/bfrr_ctrl.sv =====
module bfrr_ctrl import bfrr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  input  logic      s_cmd_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i && s_cmd_i == CMD_COMPUTE) begin
          op_d    = OP_X0;
          state_d = stat_i.zero_dim ? ST_FINISH : ST_DSTART;
        end
      end
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (stat_i.div_done) begin
          op_d = op_e'(op_q + 3'd1);
          if (op_q == OP_Y1) begin
            state_d = ST_WINIT;
          end else if (op_q == OP_M3) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_DSTART;
          end
        end
      end
      ST_WINIT: state_d = ST_WALK;
      ST_WALK: begin
        if (stat_i.walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DSTART;
      ST_FINISH: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = op_q;
    unique case (state_q)
      ST_IDLE:   cmd_o.s_ready   = 1'b1;
      ST_DSTART: cmd_o.div_start = 1'b1;
      ST_WINIT:  cmd_o.walk_init = 1'b1;
      ST_WALK:   cmd_o.walk_rd   = 1'b1;
      ST_FINISH: cmd_o.out_load  = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_X0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ===== rtl/bfrr_datapath.sv =====
module bfrr_datapath import bfrr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output dp_stat_t         stat_o,
  input  logic             load_i,
  input  logic             capture_i,
  input  logic [AddrW-1:0] load_index_i,
  input  logic [PixW-1:0]  load_pixel_i,
  input  logic [11:0]      dst_col_i,
  input  logic [11:0]      dst_row_i,
  input  logic [8:0]       src_width_i,
  input  logic [8:0]       src_height_i,
  input  logic [12:0]      dst_width_i,
  input  logic [12:0]      dst_height_i,
  input  logic             m_ready_i,
  output logic             m_valid_o,
  output logic [PixW-1:0]  m_pixel_o,
  output logic             m_produced_o
);

  logic [8:0]  sw_c, sh_c;
  logic [12:0] dw_c, dh_c;
  logic [11:0] x_c, y_c;
  logic [11:0] x_q, y_q;
  logic [SpanW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic [SpanW-1:0] sx_q, sy_q, sx_next;
  logic [AddrW-1:0] row_q, rd_addr;
  logic [CountW-1:0] count_q;
  logic [SumW-1:0] sum_q [Channels];
  logic [PixW-1:0] pix_q, rd_q, out_pix_q;
  logic prod_q, out_prod_q, out_valid_q, rd_vld_q;
  logic [PixW-1:0] mem [2**AddrW];
  logic [DivNumW-1:0] div_num, quot;
  logic [DivDenW-1:0] div_den;
  logic div_done;
  logic [1:0] ch;
  logic [SpanW-1:0] dx, dy;

  assign sw_c = (int'(src_width_i) > MaxSrcWidth) ? 9'(MaxSrcWidth) : src_width_i;
  assign sh_c = (int'(src_height_i) > MaxSrcHeight) ? 9'(MaxSrcHeight) : src_height_i;
  assign dw_c = (int'(dst_width_i) > MaxDstDim) ? 13'(MaxDstDim) : dst_width_i;
  assign dh_c = (int'(dst_height_i) > MaxDstDim) ? 13'(MaxDstDim) : dst_height_i;

  assign x_c = ({1'b0, dst_col_i} > dw_c - 13'd1) ? 12'(dw_c - 13'd1) : dst_col_i;
  assign y_c = ({1'b0, dst_row_i} > dh_c - 13'd1) ? 12'(dh_c - 13'd1) : dst_row_i;

  assign ch = 2'(cmd_i.op);
  assign dx = x1_q - x0_q;
  assign dy = y1_q - y0_q;

  always_comb begin
    unique case (cmd_i.op)
      OP_X0: begin
        div_num = DivNumW'(x_q) * DivNumW'(sw_c);
        div_den = DivDenW'(dw_c);
      end
      OP_X1: begin
        div_num = (DivNumW'(x_q) + DivNumW'(1)) * DivNumW'(sw_c);
        div_den = DivDenW'(dw_c);
      end
      OP_Y0: begin
        div_num = DivNumW'(y_q) * DivNumW'(sh_c);
        div_den = DivDenW'(dh_c);
      end
      OP_Y1: begin
        div_num = (DivNumW'(y_q) + DivNumW'(1)) * DivNumW'(sh_c);
        div_den = DivDenW'(dh_c);
      end
      OP_M0, OP_M1, OP_M2, OP_M3: begin
        div_num = DivNumW'(sum_q[ch]) + DivNumW'(count_q >> 1);
        div_den = count_q;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  bfrr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      x_q    <= x_c;
      y_q    <= y_c;
      pix_q  <= '0;
      prod_q <= !stat_o.zero_dim;
    end
    if (div_done) begin
      unique case (cmd_i.op)
        OP_X0: x0_q <= quot[SpanW-1:0];
        OP_X1: x1_q <= (quot[SpanW-1:0] <= x0_q) ? x0_q + SpanW'(1) : quot[SpanW-1:0];
        OP_Y0: y0_q <= quot[SpanW-1:0];
        OP_Y1: y1_q <= (quot[SpanW-1:0] <= y0_q) ? y0_q + SpanW'(1) : quot[SpanW-1:0];
        OP_M0, OP_M1, OP_M2, OP_M3: pix_q[{ch, 3'b000} +: 8] <= quot[7:0];
        default: ;
      endcase
    end
  end

  assign rd_addr = row_q + AddrW'(sx_q);
  assign sx_next = sx_q + SpanW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      sx_q    <= x0_q;
      sy_q    <= y0_q;
      row_q   <= AddrW'({9'b0, y0_q} * {9'b0, sw_c});
      count_q <= CountW'({9'b0, dx} * {9'b0, dy});
      for (int c = 0; c < Channels; c++) begin
        sum_q[c] <= '0;
      end
    end else begin
      if (cmd_i.walk_rd) begin
        if (sx_next == x1_q) begin
          sx_q  <= x0_q;
          sy_q  <= sy_q + SpanW'(1);
          row_q <= row_q + AddrW'(sw_c);
        end else begin
          sx_q <= sx_next;
        end
      end
      if (rd_vld_q) begin
        for (int c = 0; c < Channels; c++) begin
          sum_q[c] <= sum_q[c] + SumW'(rd_q[8*c +: 8]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mem[load_index_i] <= load_pixel_i;
    end
    if (cmd_i.walk_rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.walk_rd;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pix_q  <= pix_q;
      out_prod_q <= prod_q;
    end
  end

  assign stat_o.zero_dim  = (sw_c == '0) || (sh_c == '0) || (dw_c == '0) || (dh_c == '0);
  assign stat_o.div_done  = div_done;
  assign stat_o.walk_last = (sx_next == x1_q) && (sy_q + SpanW'(1) == y1_q);
  assign stat_o.out_free  = !out_valid_q || m_ready_i;

  assign m_valid_o    = out_valid_q;
  assign m_pixel_o    = out_pix_q;
  assign m_produced_o = out_prod_q;

endmodule

// ===== rtl/box_filter_rgba_resample_core.sv =====
// Area-average resampler for RGBA8 images.
// Requests enter on the s_axis stream. tuser selects the kind: a load writes
// one packed source pixel to the source memory, a compute names one
// destination pixel. A load gives no result; the core stays ready for more.
// A compute gives one result on the m_axis stream: the packed rounded channel
// means in tdata and, in tuser, a flag that is low when a dimension is zero.
// A compute runs four serial divisions for the source spans on a shared
// radix-2 divider, walks the source rectangle one pixel per cycle through
// the memory read port, then runs four divisions for the channel means. A
// compute with a zero dimension skips the divisions and the walk.
// One request is in work at a time; a new request is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// If the receiver stalls, the result is held and the next compute waits at
// its end until the output register frees up. Reset sets all four size
// registers to one. Source memory is not cleared. Sizes are written over
// the APB port; the user must write them only while no compute is in
// progress, as the block itself does not enforce it.

`include "assert_macros.svh"

module box_filter_rgba_resample_core import bfrr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // load_index [15:0], load_pixel [47:16], dst_col [59:48], dst_row [71:60]
  input  logic [71:0] s_axis_tdata,
  // command [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_pixel [31:0]
  output logic [31:0] m_axis_tdata,
  // produced [0]
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0]  src_width_q, src_height_q;
  logic [12:0] dst_width_q, dst_height_q;
  logic        cfg_wr, accept;
  ctrl_cmd_t   cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= 9'd1;
      src_height_q <= 9'd1;
      dst_width_q  <= 13'd1;
      dst_height_q <= 13'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SRC_WIDTH:  src_width_q  <= pwdata[8:0];
        REG_SRC_HEIGHT: src_height_q <= pwdata[8:0];
        REG_DST_WIDTH:  dst_width_q  <= pwdata[12:0];
        REG_DST_HEIGHT: dst_height_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SRC_WIDTH:  prdata = 32'(src_width_q);
      REG_SRC_HEIGHT: prdata = 32'(src_height_q);
      REG_DST_WIDTH:  prdata = 32'(dst_width_q);
      REG_DST_HEIGHT: prdata = 32'(dst_height_q);
      default:        prdata = '0;
    endcase
  end

  assign s_axis_tready = cmd.s_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bfrr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_cmd_i   (s_axis_tuser),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  bfrr_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .load_i       (accept && s_axis_tuser == CMD_LOAD),
    .capture_i    (accept && s_axis_tuser == CMD_COMPUTE),
    .load_index_i (s_axis_tdata[15:0]),
    .load_pixel_i (s_axis_tdata[47:16]),
    .dst_col_i    (s_axis_tdata[59:48]),
    .dst_row_i    (s_axis_tdata[71:60]),
    .src_width_i  (src_width_q),
    .src_height_i (src_height_q),
    .dst_width_i  (dst_width_q),
    .dst_height_i (dst_height_q),
    .m_ready_i    (m_axis_tready),
    .m_valid_o    (m_axis_tvalid),
    .m_pixel_o    (m_axis_tdata),
    .m_produced_o (m_axis_tuser)
  );

  `BFRR_ASSERT(a_div_not_idle, clk_i, rst_ni, stat.div_done |-> !cmd.s_ready)
  `BFRR_ASSERT(a_load_when_free, clk_i, rst_ni, cmd.out_load |-> stat.out_free)
  `BFRR_ASSERT(a_one_cmd, clk_i, rst_ni,
    $onehot0({cmd.div_start, cmd.walk_init, cmd.walk_rd, cmd.out_load}))

endmodule

// ===== dv/tb_box_filter_rgba_resample_core.sv =====
`timescale 1ns / 100ps

class resample_scoreboard;
  bit [31:0]   src_mem [65536];
  int unsigned src_w = 1, src_h = 1, dst_w = 1, dst_h = 1;
  bit [31:0]   exp_pixel [$];
  bit          exp_flag [$];
  int          errors, n_loads, n_computes, n_empty, n_checked;

  function void set_size(logic [1:0] idx, bit [31:0] v);
    case (idx)
      bfrr_pkg::REG_SRC_WIDTH:  src_w = v & 32'h1FF;
      bfrr_pkg::REG_SRC_HEIGHT: src_h = v & 32'h1FF;
      bfrr_pkg::REG_DST_WIDTH:  dst_w = v & 32'h1FFF;
      default:                  dst_h = v & 32'h1FFF;
    endcase
  endfunction

  function void src_span(int unsigned c, int unsigned s, int unsigned d,
                         output int unsigned lo, output int unsigned hi);
    lo = c * s / d;
    hi = (c + 1) * s / d;
    if (hi <= lo) hi = lo + 1;
  endfunction

  function void note_request(bit cmd, bit [71:0] d);
    int unsigned sw, sh, dw, dh, x, y, x0, x1, y0, y1, cnt;
    int unsigned sum [4];
    bit [31:0]   p, packed_mean;
    if (cmd == bfrr_pkg::CMD_LOAD) begin
      src_mem[d[15:0]] = d[47:16];
      n_loads++;
      return;
    end
    n_computes++;
    sw = (src_w > 256) ? 256 : src_w;
    sh = (src_h > 256) ? 256 : src_h;
    dw = (dst_w > 4096) ? 4096 : dst_w;
    dh = (dst_h > 4096) ? 4096 : dst_h;
    if (sw == 0 || sh == 0 || dw == 0 || dh == 0) begin
      n_empty++;
      exp_pixel.push_back(32'd0);
      exp_flag.push_back(1'b0);
      return;
    end
    x = (d[59:48] > dw - 1) ? dw - 1 : 32'(d[59:48]);
    y = (d[71:60] > dh - 1) ? dh - 1 : 32'(d[71:60]);
    src_span(x, sw, dw, x0, x1);
    src_span(y, sh, dh, y0, y1);
    sum = '{0, 0, 0, 0};
    for (int unsigned sy = y0; sy < y1; sy++) begin
      for (int unsigned sx = x0; sx < x1; sx++) begin
        p = src_mem[16'(sy * sw + sx)];
        for (int ch = 0; ch < 4; ch++) sum[ch] += 32'(p[8*ch +: 8]);
      end
    end
    cnt = (y1 - y0) * (x1 - x0);
    for (int ch = 0; ch < 4; ch++) packed_mean[8*ch +: 8] = 8'((sum[ch] + cnt / 2) / cnt);
    exp_pixel.push_back(packed_mean);
    exp_flag.push_back(1'b1);
  endfunction

  function void check_result(bit [31:0] pix, bit flag);
    bit [31:0] ep;
    bit        ef;
    if (exp_pixel.size() == 0) begin
      $display("%0t: unexpected result pixel %h flag %b", $time, pix, flag);
      errors++;
      return;
    end
    ep = exp_pixel.pop_front();
    ef = exp_flag.pop_front();
    n_checked++;
    if (pix !== ep) begin
      $display("%0t: pixel mismatch expected %h actual %h", $time, ep, pix);
      errors++;
    end
    if (flag !== ef) begin
      $display("%0t: produced mismatch expected %b actual %b", $time, ef, flag);
      errors++;
    end
  endfunction
endclass

module tb_box_filter_rgba_resample_core;
  import bfrr_pkg::*;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [31:0] m_axis_tdata;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  resample_scoreboard sb = new();
  bit steady;
  bit hold_go;
  int hold_left;

  box_filter_rgba_resample_core i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb_box_filter_rgba_resample_core NOT OK");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 7);
    end
  end

  task automatic send(bit cmd, bit [15:0] idx, bit [31:0] pix, bit [11:0] col,
                      bit [11:0] row);
    if (!steady && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {row, col, pix, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(cmd, {row, col, pix, idx});
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.exp_pixel.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, bit [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_size(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw,
                           int unsigned dh);
    wait_idle();
    apb_write(REG_SRC_WIDTH, sw);
    apb_write(REG_SRC_HEIGHT, sh);
    apb_write(REG_DST_WIDTH, dw);
    apb_write(REG_DST_HEIGHT, dh);
  endtask

  task automatic compute(bit [11:0] col, bit [11:0] row);
    send(CMD_COMPUTE, 16'($urandom), $urandom, col, row);
  endtask

  task automatic run_phase(int unsigned sw, int unsigned sh, int unsigned dw,
                           int unsigned dh, int ncomp, int nnoise);
    int unsigned ew, eh, cw, chh;
    bit [11:0]   col, row;
    set_sizes(sw, sh, dw, dh);
    ew  = (sw > 256) ? 256 : sw;
    eh  = (sh > 256) ? 256 : sh;
    cw  = (dw > 4096) ? 4096 : dw;
    chh = (dh > 4096) ? 4096 : dh;
    for (int unsigned i = 0; i < ew * eh; i++)
      send(CMD_LOAD, 16'(i), $urandom, 12'($urandom), 12'($urandom));
    repeat (nnoise)
      send(CMD_LOAD, 16'($urandom), $urandom, 12'($urandom), 12'($urandom));
    repeat (ncomp) begin
      col = (cw == 0 || $urandom_range(99) < 15) ? 12'($urandom)
                                                 : 12'($urandom_range(0, cw - 1));
      row = (chh == 0 || $urandom_range(99) < 15) ? 12'($urandom)
                                                  : 12'($urandom_range(0, chh - 1));
      compute(col, row);
    end
  endtask

  initial begin
    int unsigned sw, sh;
    int          ph;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= CMD_LOAD;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    steady = 1'b0;
    hold_go = 1'b0;
    hold_left = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sizes after reset, full-scale pixels and coordinates that saturate.
    send(CMD_LOAD, 16'h0000, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
    compute(12'd0, 12'd0);
    compute(12'hFFF, 12'hFFF);
    send(CMD_LOAD, 16'hFFFF, 32'h0000_0000, 12'd0, 12'd0);
    send(CMD_LOAD, 16'h0000, 32'h0000_0000, 12'd0, 12'd0);
    compute(12'd0, 12'd0);

    // Widest and tallest sources, oversized registers saturate.
    set_sizes(511, 1, 8191, 8191);
    send(CMD_LOAD, 16'd0, 32'h80FF_017F, 12'd0, 12'd0);
    send(CMD_LOAD, 16'd255, 32'h01FE_7F80, 12'd0, 12'd0);
    compute(12'd0, 12'd0);
    compute(12'd4095, 12'd4095);
    set_sizes(1, 300, 1, 4096);
    compute(12'd0, 12'd0);
    compute(12'd0, 12'd4095);

    // Each size register at zero in turn.
    for (int i = 0; i < 4; i++) begin
      run_phase(i == 0 ? 0 : 2, i == 1 ? 0 : 2, i == 2 ? 0 : 2, i == 3 ? 0 : 2, 2, 0);
    end

    // A large rectangle averaged into a single pixel.
    run_phase(16, 16, 1, 1, 2, 0);

    ph = 0;
    while (sb.n_loads + sb.n_computes < 950) begin
      steady = (ph >= 6 && ph < 10);
      if ($urandom_range(9) == 0) begin
        sw = $urandom_range(9, 24);
        sh = $urandom_range(1, 4);
      end else begin
        sw = $urandom_range(1, 8);
        sh = $urandom_range(1, 8);
      end
      if (ph == 3) begin
        run_phase(sw, sh, $urandom_range(1, 10), $urandom_range(1, 10), 0, 0);
        hold_go = 1'b1;
        repeat (12) compute(12'($urandom_range(0, 15)), 12'($urandom_range(0, 15)));
      end else begin
        run_phase(sw, sh, $urandom_range(1, 12), $urandom_range(1, 12),
                  $urandom_range(5, 20), $urandom_range(0, 2));
      end
      ph++;
    end
    steady = 1'b0;

    wait_idle();
    repeat (300) @(posedge clk_i);
    $display("Covered %0d loads and %0d computes, %0d of them with a zero size.",
             sb.n_loads, sb.n_computes, sb.n_empty);
    $display("%0d results checked, %0d errors.", sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.exp_pixel.size() == 0) begin
      $display("tb_box_filter_rgba_resample_core OK");
    end else begin
      $display("tb_box_filter_rgba_resample_core NOT OK");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/bfrr_pkg.sv
rtl/bfrr_div.sv
rtl/bfrr_ctrl.sv
rtl/bfrr_datapath.sv
rtl/box_filter_rgba_resample_core.sv
dv/tb_box_filter_rgba_resample_core.sv
